// ===== rtl/core/cepgs_pkg.sv =====
// Shared types, particle codes and the class decoder for the group energy summer.
package cepgs_pkg;

    typedef enum logic [2:0] {
        ST_HIT,
        ST_UPD,
        ST_SCAN,
        ST_LOAD,
        ST_EMPTY
    } t_state;

    typedef enum logic [1:0] {
        CLS_PION,
        CLS_MUON,
        CLS_MIP,
        CLS_NONE
    } t_cls;

    localparam logic signed [31:0] CODE_PION    = 32'sd211;
    localparam logic signed [31:0] CODE_MUON    = -32'sd13;
    localparam logic signed [31:0] CODE_ELEC    = 32'sd11;
    localparam logic signed [31:0] CODE_POSITRON = -32'sd11;

    function automatic t_cls class_of(input logic signed [31:0] code);
        t_cls c;
        if (code == CODE_PION) begin
            c = CLS_PION;
        end else if (code == CODE_MUON) begin
            c = CLS_MUON;
        end else if (code == CODE_ELEC || code == CODE_POSITRON) begin
            c = CLS_MIP;
        end else begin
            c = CLS_NONE;
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/class_energy_per_group_sum_unit.sv =====
// Top level: per-event energy sums by time group and particle class.
//
// Hits stream in on the hit channel, one word per hit. Codes 211 (pion), -13 (muon)
// and +/-11 (electron/positron) are classified; any other code is ignored. Energy
// is accumulated per group and class in a single-port sum memory (three SUM_BITS
// sums per word), saturating at 2^SUM_BITS - 1. A classified hit whose group is at
// or above GROUPS is dropped and sets the event's dropped flag. Each hit is first
// accepted with its memory read issued, then added and written back, and no new
// hit is taken before that write-back (the registered read port needs this). After
// the last hit's write-back the block scans the presence map one group per cycle,
// passing through a load state for each present group's read, and stops after the
// highest present group; it emits one result word per present group in ascending
// order. With no group present it scans all GROUPS entries and then loads a single
// empty word. A stall on the result side holds the block in its load states. The
// result word sits in an output register, so the next event's first hit is taken
// while the final result still waits. Presence bits and the dropped flag clear at
// the end of emission; the sum memory needs no clearing, since a group's first hit
// overwrites its entry.
module class_energy_per_group_sum_unit #(
    parameter int GROUPS   = 16,
    parameter int SUM_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // hit channel
    input  logic               i_hit_valid,
    output logic               o_hit_ready,
    input  logic signed [31:0] i_particle_code,
    input  logic [23:0]        i_energy,
    input  logic [7:0]         i_group_index,
    input  logic               i_last_hit,
    // result channel
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic [3:0]         o_group_id,
    output logic [31:0]        o_pion_sum,
    output logic [31:0]        o_muon_sum,
    output logic [31:0]        o_mip_sum,
    output logic               o_has_group,
    output logic               o_dropped_hits,
    output logic               o_last_result
);

    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int WW = 3 * SUM_BITS;
    // adder width: wide enough for either operand plus carry
    localparam int AW = ((SUM_BITS > 24) ? SUM_BITS : 24) + 1;
    localparam logic [SUM_BITS-1:0] MaxSum = '1;

    // sum memory, word = {mip, muon, pion}
    logic [WW-1:0] r_mem [GROUPS];
    logic [WW-1:0] r_rd_data;

    cepgs_pkg::t_state r_state, n_state;

    logic [GROUPS-1:0] r_present;
    logic              r_overflow;
    logic [GW-1:0]     r_ptr;

    // captured hit
    cepgs_pkg::t_cls r_cls;
    logic [23:0]     r_energy;
    logic [GW-1:0]   r_grp;
    logic            r_last;
    logic            r_upd;

    // output register
    logic          r_o_valid;
    logic [3:0]    r_o_group;
    logic [31:0]   r_o_pion, r_o_muon, r_o_mip;
    logic          r_o_has, r_o_drop, r_o_last;

    // control
    logic          hit_ready, hit_acc;
    logic          rd_en;
    logic [GW-1:0] rd_addr;
    logic          wr_en;
    logic          out_load, out_empty;
    logic          ptr_clr, ptr_inc;
    logic          ev_clear;
    logic          load_ok;
    logic          more_above;
    logic          ptr_at_end;

    cepgs_pkg::t_cls hit_cls;
    logic            hit_in_range;

    // read-modify-write datapath
    logic [SUM_BITS-1:0] old_sel;
    logic [AW-1:0]       wide;
    logic [SUM_BITS-1:0] sat_sum;
    logic [WW-1:0]       base_word, n_word;

    assign hit_cls      = cepgs_pkg::class_of(i_particle_code);
    assign hit_in_range = (i_group_index < 8'(GROUPS));
    assign hit_acc      = i_hit_valid && hit_ready;
    assign load_ok      = !r_o_valid || i_res_ready;
    assign ptr_at_end   = (r_ptr == GW'(GROUPS - 1));

    // any present group past the scan pointer decides last_result
    always_comb begin
        more_above = 1'b0;
        for (int j = 0; j < GROUPS; j++) begin
            if (r_present[j] && (GW'(j) > r_ptr)) begin
                more_above = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cepgs_pkg::ST_HIT: begin
                if (hit_acc) begin
                    n_state = cepgs_pkg::ST_UPD;
                end
            end
            cepgs_pkg::ST_UPD: begin
                n_state = r_last ? cepgs_pkg::ST_SCAN : cepgs_pkg::ST_HIT;
            end
            cepgs_pkg::ST_SCAN: begin
                if (r_present[r_ptr]) begin
                    n_state = cepgs_pkg::ST_LOAD;
                end else if (ptr_at_end) begin
                    n_state = cepgs_pkg::ST_EMPTY;
                end
            end
            cepgs_pkg::ST_LOAD: begin
                if (load_ok) begin
                    n_state = more_above ? cepgs_pkg::ST_SCAN : cepgs_pkg::ST_HIT;
                end
            end
            cepgs_pkg::ST_EMPTY: begin
                if (load_ok) begin
                    n_state = cepgs_pkg::ST_HIT;
                end
            end
            default: n_state = cepgs_pkg::ST_HIT;
        endcase
    end

    // state outputs
    always_comb begin
        hit_ready = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = r_ptr;
        wr_en     = 1'b0;
        out_load  = 1'b0;
        out_empty = 1'b0;
        ptr_clr   = 1'b0;
        ptr_inc   = 1'b0;
        ev_clear  = 1'b0;
        case (r_state)
            cepgs_pkg::ST_HIT: begin
                hit_ready = 1'b1;
                rd_addr   = i_group_index[GW-1:0];
                rd_en     = hit_acc && hit_in_range && (hit_cls != cepgs_pkg::CLS_NONE);
            end
            cepgs_pkg::ST_UPD: begin
                wr_en   = r_upd;
                ptr_clr = r_last;
            end
            cepgs_pkg::ST_SCAN: begin
                if (r_present[r_ptr]) begin
                    rd_en = 1'b1;
                end else if (!ptr_at_end) begin
                    ptr_inc = 1'b1;
                end
            end
            cepgs_pkg::ST_LOAD: begin
                if (load_ok) begin
                    out_load = 1'b1;
                    ptr_inc  = more_above;
                    ev_clear = !more_above;
                end
            end
            cepgs_pkg::ST_EMPTY: begin
                if (load_ok) begin
                    out_load  = 1'b1;
                    out_empty = 1'b1;
                    ev_clear  = 1'b1;
                end
            end
            default: begin
                hit_ready = 1'b0;
            end
        endcase
    end

    // saturating add on the hit's class
    always_comb begin
        base_word = r_present[r_grp] ? r_rd_data : '0;
        case (r_cls)
            cepgs_pkg::CLS_PION: old_sel = base_word[0*SUM_BITS +: SUM_BITS];
            cepgs_pkg::CLS_MUON: old_sel = base_word[1*SUM_BITS +: SUM_BITS];
            cepgs_pkg::CLS_MIP:  old_sel = base_word[2*SUM_BITS +: SUM_BITS];
            default:             old_sel = '0;
        endcase
        wide    = AW'(old_sel) + AW'(r_energy);
        sat_sum = (wide > AW'(MaxSum)) ? MaxSum : wide[SUM_BITS-1:0];
        n_word  = base_word;
        case (r_cls)
            cepgs_pkg::CLS_PION: n_word[0*SUM_BITS +: SUM_BITS] = sat_sum;
            cepgs_pkg::CLS_MUON: n_word[1*SUM_BITS +: SUM_BITS] = sat_sum;
            cepgs_pkg::CLS_MIP:  n_word[2*SUM_BITS +: SUM_BITS] = sat_sum;
            default:             n_word = base_word;
        endcase
    end

    // sum memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_grp] <= n_word;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cepgs_pkg::ST_HIT;
            r_present  <= '0;
            r_overflow <= 1'b0;
            r_ptr      <= '0;
            r_upd      <= 1'b0;
            r_last     <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (hit_acc) begin
                r_upd  <= hit_in_range && (hit_cls != cepgs_pkg::CLS_NONE);
                r_last <= i_last_hit;
                if (!hit_in_range && (hit_cls != cepgs_pkg::CLS_NONE)) begin
                    r_overflow <= 1'b1;
                end
            end
            if (wr_en) begin
                r_present[r_grp] <= 1'b1;
            end
            if (ptr_clr) begin
                r_ptr <= '0;
            end else if (ptr_inc) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (ev_clear) begin
                r_present  <= '0;
                r_overflow <= 1'b0;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // hit capture and output payload
    always_ff @(posedge i_clk) begin
        if (hit_acc) begin
            r_cls    <= hit_cls;
            r_energy <= i_energy;
            r_grp    <= i_group_index[GW-1:0];
        end
        if (out_load) begin
            r_o_drop <= r_overflow;
            if (out_empty) begin
                r_o_group <= '0;
                r_o_pion  <= '0;
                r_o_muon  <= '0;
                r_o_mip   <= '0;
                r_o_has   <= 1'b0;
                r_o_last  <= 1'b1;
            end else begin
                r_o_group <= 4'(r_ptr);
                r_o_pion  <= 32'(r_rd_data[0*SUM_BITS +: SUM_BITS]);
                r_o_muon  <= 32'(r_rd_data[1*SUM_BITS +: SUM_BITS]);
                r_o_mip   <= 32'(r_rd_data[2*SUM_BITS +: SUM_BITS]);
                r_o_has   <= 1'b1;
                r_o_last  <= !more_above;
            end
        end
    end

    assign o_hit_ready    = hit_ready;
    assign o_res_valid    = r_o_valid;
    assign o_group_id     = r_o_group;
    assign o_pion_sum     = r_o_pion;
    assign o_muon_sum     = r_o_muon;
    assign o_mip_sum      = r_o_mip;
    assign o_has_group    = r_o_has;
    assign o_dropped_hits = r_o_drop;
    assign o_last_result  = r_o_last;

endmodule

// ===== rtl/core/cepgs_checker.sv =====
// Port-level checker for the group energy summer, bound to the top level.
module cepgs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_hit_valid,
    input logic               o_hit_ready,
    input logic signed [31:0] i_particle_code,
    input logic [23:0]        i_energy,
    input logic [7:0]         i_group_index,
    input logic               i_last_hit,
    input logic               o_res_valid,
    input logic               i_res_ready,
    input logic [3:0]         o_group_id,
    input logic [31:0]        o_pion_sum,
    input logic [31:0]        o_muon_sum,
    input logic [31:0]        o_mip_sum,
    input logic               o_has_group,
    input logic               o_dropped_hits,
    input logic               o_last_result
);

    // stalled result word holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_group_id)
            && $stable(o_pion_sum) && $stable(o_muon_sum) && $stable(o_mip_sum)
            && $stable(o_has_group) && $stable(o_last_result))
        else $error("result word changed while stalled");

    // every hit needs its write-back before the next hit is accepted
    a_hit_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hit_valid && o_hit_ready |=> !o_hit_ready)
        else $error("hit accepted during write-back");

    // empty result is all zero and closes the event
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_has_group |-> o_last_result && o_group_id == 4'd0
            && o_pion_sum == 32'd0 && o_muon_sum == 32'd0 && o_mip_sum == 32'd0)
        else $error("malformed empty result");

    // dropped flag is the same on every word of an event
    a_drop_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_ready && !o_last_result
            |=> !o_res_valid || $stable(o_dropped_hits))
        else $error("dropped flag changed within event");

endmodule

bind class_energy_per_group_sum_unit cepgs_checker u_cepgs_checker (.*);
